FILE: rtl/tun_pkg.sv
// shared widths and the payload type for the triangle unit normal pipeline
`default_nettype none

package tun_pkg;

    localparam int NUM_AXES   = 3;
    localparam int NUM_VERTS  = 3;
    localparam int COORD_W    = 16;
    localparam int EDGE_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * EDGE_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MAG_W      = CROSS_W - 1;
    localparam int HALF_W     = MAG_W / 2;
    localparam int PART_W     = 2 * HALF_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int REM_W      = ROOT_W + 3;
    localparam int FRAC_BITS  = 12;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int NORM_W     = QUO_W + 1;
    localparam int DIV_STAGES = QUO_W + 2;
    localparam int IN_DATA_W  = NUM_AXES * NUM_VERTS * COORD_W;
    localparam int OUT_BITS   = NUM_AXES * NORM_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // cross product carried as sign and magnitude per axis
    typedef struct packed {
        logic [NUM_AXES-1:0]            sign;
        logic [NUM_AXES-1:0][MAG_W-1:0] mag;
    } cross_t;

endpackage

`default_nettype wire

FILE: rtl/triangle_unit_normal_top.sv
// top level of the triangle unit normal pipeline with output skid stage
//
// Usage:
//   s_* channel: one triangle per transaction, nine signed 16-bit coordinates
//   m_* channel: one unit normal per triangle, components in signed 2.12 fixed point
//     with a degenerate flag in m_tuser (normal then zero)
//   Throughput: one triangle per cycle while s_tready is high; the square
//     root pipeline (35 root steps) and the dividers (13 quotient steps)
//     each retire one item a cycle while the pipeline is not frozen.
//   Stall: when m_tready is low the finished result is held in the output
//     register; one more result goes into a skid register, and only when that
//     skid register is full does the pipeline freeze and s_tready drop.
//   Reset: rst_n clears all valid bits; the data registers are not reset.
`default_nettype none

module triangle_unit_normal_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each, lowest first)
    input  wire logic [tun_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // norm_x, norm_y, norm_z (14 bits each, lowest first), zero padded
    output logic [tun_pkg::OUT_DATA_W-1:0]       m_tdata,
    // degenerate
    output logic                                 m_tuser
);

    localparam int NW = tun_pkg::NORM_W;
    localparam int DS = tun_pkg::DIV_STAGES;
    localparam int RW = tun_pkg::ROOT_W;

    logic                 ce;
    logic                 cr_valid;
    tun_pkg::cross_t      cr_data;
    logic                 sq_valid;
    tun_pkg::cross_t      sq_data;
    logic [RW-1:0]        sq_len;
    logic signed [NW-1:0] div_norm [3];

    logic [DS-1:0]        dv_reg;
    logic [DS-1:0]        dg_reg;

    logic [3*NW-1:0]      end_norm;
    logic                 end_deg;

    logic                 out_valid_reg;
    logic [3*NW-1:0]      out_norm_reg;
    logic                 out_deg_reg;
    logic                 skid_valid_reg;
    logic [3*NW-1:0]      skid_norm_reg;
    logic                 skid_deg_reg;

    // pipeline advances while the skid register is free
    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    tun_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .verts     (s_tdata),
        .out_valid (cr_valid),
        .out_data  (cr_data)
    );

    tun_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (cr_valid),
        .in_data   (cr_data),
        .out_valid (sq_valid),
        .out_data  (sq_data),
        .len       (sq_len)
    );

    for (genvar a = 0; a < 3; a++)
    begin : g_div
        tun_div u_div (
            .clk  (clk),
            .ce   (ce),
            .mag  (sq_data.mag[a]),
            .sign (sq_data.sign[a]),
            .len  (sq_len),
            .norm (div_norm[a])
        );
    end

    // valid and degenerate flag run beside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= '0;
        end
        else if (ce)
        begin
            dv_reg <= {dv_reg[DS-2:0], sq_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dg_reg <= {dg_reg[DS-2:0], (sq_len == '0)};
        end
    end

    // a degenerate triangle gives a zero normal
    assign end_deg  = dg_reg[DS-1];
    assign end_norm = end_deg ? '0 : {div_norm[2], div_norm[1], div_norm[0]};

    // output register and skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (dv_reg[DS-1])
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_norm_reg <= skid_norm_reg;
                out_deg_reg  <= skid_deg_reg;
            end
        end
        else if (dv_reg[DS-1])
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_norm_reg <= end_norm;
                skid_deg_reg  <= end_deg;
            end
            else
            begin
                out_norm_reg <= end_norm;
                out_deg_reg  <= end_deg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tun_pkg::OUT_DATA_W - 3*NW){1'b0}}, out_norm_reg};
    assign m_tuser  = out_deg_reg;

`ifndef ASSERT_OFF
    a_skid_implies_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_ready_low_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !$past(m_tready)))
        else $error("input stalled without a stalled output");

    a_degenerate_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("degenerate result with non-zero normal");

    a_norm_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (($signed(out_norm_reg[NW-1:0]) >= -14'sd4096)
                   && ($signed(out_norm_reg[NW-1:0]) <= 14'sd4096)
                   && ($signed(out_norm_reg[2*NW-1:NW]) >= -14'sd4096)
                   && ($signed(out_norm_reg[2*NW-1:NW]) <= 14'sd4096)
                   && ($signed(out_norm_reg[3*NW-1:2*NW]) >= -14'sd4096)
                   && ($signed(out_norm_reg[3*NW-1:2*NW]) <= 14'sd4096)))
        else $error("normal component outside unit range");
`endif

endmodule

`default_nettype wire

FILE: rtl/tun_cross.sv
// edge vectors and cross product, four register stages
`default_nettype none

module tun_cross (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         ce,
    input  wire logic                         in_valid,
    input  wire logic [tun_pkg::IN_DATA_W-1:0] verts,
    output logic                              out_valid,
    output tun_pkg::cross_t                   out_data
);

    localparam int CW = tun_pkg::COORD_W;
    localparam int EW = tun_pkg::EDGE_W;
    localparam int PW = tun_pkg::PROD_W;
    localparam int NW = tun_pkg::CROSS_W;
    localparam int MW = tun_pkg::MAG_W;

    logic [3:0] vld_reg;

    logic signed [EW-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [PW-1:0] prod_reg [6];
    logic signed [NW-1:0] n_reg [3];
    tun_pkg::cross_t      res_reg;

    logic signed [EW-1:0] ext [9];

    // sign-extend the nine coordinates
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            ext[k] = $signed({verts[k*CW + CW-1], verts[k*CW +: CW]});
        end
    end

    // valid bits follow the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // edges, products, differences, magnitudes
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ux_reg <= ext[3] - ext[0];
            uy_reg <= ext[4] - ext[1];
            uz_reg <= ext[5] - ext[2];
            vx_reg <= ext[6] - ext[0];
            vy_reg <= ext[7] - ext[1];
            vz_reg <= ext[8] - ext[2];

            prod_reg[0] <= uy_reg * vz_reg;
            prod_reg[1] <= uz_reg * vy_reg;
            prod_reg[2] <= uz_reg * vx_reg;
            prod_reg[3] <= ux_reg * vz_reg;
            prod_reg[4] <= ux_reg * vy_reg;
            prod_reg[5] <= uy_reg * vx_reg;

            for (int a = 0; a < 3; a++)
            begin
                n_reg[a] <= $signed({prod_reg[2*a][PW-1], prod_reg[2*a]})
                          - $signed({prod_reg[2*a+1][PW-1], prod_reg[2*a+1]});
            end

            for (int a = 0; a < 3; a++)
            begin
                res_reg.sign[a] <= n_reg[a][NW-1];
                res_reg.mag[a]  <= n_reg[a][NW-1] ? MW'(-n_reg[a]) : MW'(n_reg[a]);
            end
        end
    end

    assign out_valid = vld_reg[3];
    assign out_data  = res_reg;

endmodule

`default_nettype wire

FILE: rtl/tun_sqrt.sv
// squared length and pipelined floor square root, one root bit a stage
`default_nettype none

module tun_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       ce,
    input  wire logic                       in_valid,
    input  wire tun_pkg::cross_t            in_data,
    output logic                            out_valid,
    output tun_pkg::cross_t                 out_data,
    output logic [tun_pkg::ROOT_W-1:0]      len
);

    localparam int HW = tun_pkg::HALF_W;
    localparam int PTW = tun_pkg::PART_W;
    localparam int QW = tun_pkg::SQ_W;
    localparam int SW = tun_pkg::SUM_W;
    localparam int RW = tun_pkg::ROOT_W;
    localparam int MW = tun_pkg::REM_W;

    typedef struct packed {
        logic [SW-1:0]   rad;
        logic [MW-1:0]   rem;
        logic [RW-1:0]   root;
        tun_pkg::cross_t data;
    } root_stage_t;

    logic                v5_reg, v6_reg;
    logic [PTW-1:0]      hh_reg [3];
    logic [PTW-1:0]      hl_reg [3];
    logic [PTW-1:0]      ll_reg [3];
    logic [QW-1:0]       sq_reg [3];
    tun_pkg::cross_t     d5_reg, d6_reg;
    root_stage_t         stg_reg [RW+1];
    logic [RW:0]         stg_vld_reg;

    // front valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg         <= 1'b0;
            v6_reg         <= 1'b0;
            stg_vld_reg[0] <= 1'b0;
        end
        else if (ce)
        begin
            v5_reg         <= in_valid;
            v6_reg         <= v5_reg;
            stg_vld_reg[0] <= v6_reg;
        end
    end

    // half-word partial products, squares, sum
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int a = 0; a < 3; a++)
            begin
                hh_reg[a] <= in_data.mag[a][2*HW-1:HW] * in_data.mag[a][2*HW-1:HW];
                hl_reg[a] <= in_data.mag[a][2*HW-1:HW] * in_data.mag[a][HW-1:0];
                ll_reg[a] <= in_data.mag[a][HW-1:0] * in_data.mag[a][HW-1:0];
                sq_reg[a] <= (QW'(hh_reg[a]) << (2*HW)) + (QW'(hl_reg[a]) << (HW+1))
                           + QW'(ll_reg[a]);
            end
            d5_reg <= in_data;
            d6_reg <= d5_reg;
            stg_reg[0].rad  <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            stg_reg[0].rem  <= '0;
            stg_reg[0].root <= '0;
            stg_reg[0].data <= d6_reg;
        end
    end

    // one restoring root step per stage
    for (genvar i = 0; i < RW; i++)
    begin : g_root
        logic [MW-1:0] cur;
        logic [MW-1:0] trial;
        logic          fits;

        always_comb
        begin
            cur   = {stg_reg[i].rem[MW-3:0], stg_reg[i].rad[SW-1 -: 2]};
            trial = MW'({stg_reg[i].root, 2'b01});
            fits  = (cur >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stg_vld_reg[i+1] <= 1'b0;
            end
            else if (ce)
            begin
                stg_vld_reg[i+1] <= stg_vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                stg_reg[i+1].rad  <= stg_reg[i].rad << 2;
                stg_reg[i+1].rem  <= fits ? (cur - trial) : cur;
                stg_reg[i+1].root <= {stg_reg[i].root[RW-2:0], fits};
                stg_reg[i+1].data <= stg_reg[i].data;
            end
        end
    end

    assign out_valid = stg_vld_reg[RW];
    assign out_data  = stg_reg[RW].data;
    assign len       = stg_reg[RW].root;

endmodule

`default_nettype wire

FILE: rtl/tun_div.sv
// pipelined restoring divider: (mag << 12) / len, one quotient bit a stage
`default_nettype none

module tun_div (
    input  wire logic                          clk,
    input  wire logic                          ce,
    input  wire logic [tun_pkg::MAG_W-1:0]     mag,
    input  wire logic                          sign,
    input  wire logic [tun_pkg::ROOT_W-1:0]    len,
    output logic signed [tun_pkg::NORM_W-1:0]  norm
);

    localparam int RW = tun_pkg::ROOT_W;
    localparam int MW = tun_pkg::MAG_W;
    localparam int QW = tun_pkg::QUO_W;
    localparam int NW = tun_pkg::NORM_W;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic          pend;
        logic [RW-1:0] len;
        logic          sign;
        logic [QW-1:0] quo;
    } div_stage_t;

    div_stage_t          st_reg [QW+1];
    logic signed [NW-1:0] norm_reg;

    // the quotient stays below 2^13, so the top dividend bits start as remainder
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            st_reg[0].rem  <= RW'(mag[MW-1:1]);
            st_reg[0].pend <= mag[0];
            st_reg[0].len  <= len;
            st_reg[0].sign <= sign;
            st_reg[0].quo  <= '0;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [RW:0] r2;
        logic [RW:0] dsr;
        logic        ge;
        logic [RW:0] diff;

        always_comb
        begin
            r2   = {st_reg[k].rem, st_reg[k].pend};
            dsr  = {1'b0, st_reg[k].len};
            ge   = (r2 >= dsr);
            diff = r2 - dsr;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                st_reg[k+1].rem  <= ge ? diff[RW-1:0] : r2[RW-1:0];
                st_reg[k+1].pend <= 1'b0;
                st_reg[k+1].len  <= st_reg[k].len;
                st_reg[k+1].sign <= st_reg[k].sign;
                st_reg[k+1].quo  <= {st_reg[k].quo[QW-2:0], ge};
            end
        end
    end

    // apply the sign
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            norm_reg <= st_reg[QW].sign ? -$signed(NW'(st_reg[QW].quo))
                                        : $signed(NW'(st_reg[QW].quo));
        end
    end

    assign norm = norm_reg;

endmodule

`default_nettype wire

FILE: tb/sv/triangle_unit_normal_top_tb.sv
// self-checking testbench for the triangle unit normal pipeline
`timescale 1ns / 1ps

module triangle_unit_normal_top_tb;

    localparam int LATENCY    = 58;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic signed [tun_pkg::NORM_W-1:0] nx;
        logic signed [tun_pkg::NORM_W-1:0] ny;
        logic signed [tun_pkg::NORM_W-1:0] nz;
        logic                              degen;
    } normal_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [tun_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [tun_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tuser;

    normal_t expected_normals[$];
    int      errors;
    int      triangles_sent;
    int      normals_checked;
    int      degenerate_seen;
    int      send_gap_pct;
    int      recv_stall_pct;
    bit      hold_off;
    int      idle_cycles;

    triangle_unit_normal_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor square root of a wide unsigned value
    function automatic logic [39:0] floor_sqrt(input logic [79:0] val);
        logic [39:0] root;
        logic [39:0] trial;
        root = '0;
        for (int b = 36; b >= 0; b--)
        begin
            trial = root | (40'd1 << b);
            if ({40'd0, trial} * {40'd0, trial} <= val)
                root = trial;
        end
        return root;
    endfunction

    // scaled component divided by the length, truncated toward zero
    function automatic logic signed [tun_pkg::NORM_W-1:0] scaled_component(
        input logic signed [39:0] n, input logic [39:0] len);
        logic [63:0] mag;
        logic [63:0] quo;
        mag = n < 0 ? 64'(-n) : 64'(n);
        quo = (mag << tun_pkg::FRAC_BITS) / {24'd0, len};
        return n < 0 ? tun_pkg::NORM_W'(-quo) : tun_pkg::NORM_W'(quo);
    endfunction

    // expected unit normal of one triangle
    function automatic normal_t predict_normal(
        input logic [tun_pkg::IN_DATA_W-1:0] tri_data);
        logic signed [39:0] c[9];
        logic signed [39:0] ux, uy, uz, vx, vy, vz, nx, ny, nz;
        logic [79:0]        sq;
        logic [39:0]        len;
        normal_t            r;
        for (int i = 0; i < 9; i++)
            c[i] = 40'(signed'(tri_data[i*tun_pkg::COORD_W +: tun_pkg::COORD_W]));
        ux = c[3] - c[0];
        uy = c[4] - c[1];
        uz = c[5] - c[2];
        vx = c[6] - c[0];
        vy = c[7] - c[1];
        vz = c[8] - c[2];
        nx = uy * vz - uz * vy;
        ny = uz * vx - ux * vz;
        nz = ux * vy - uy * vx;
        sq = 80'(signed'(nx)) * 80'(signed'(nx)) + 80'(signed'(ny)) * 80'(signed'(ny))
            + 80'(signed'(nz)) * 80'(signed'(nz));
        len = floor_sqrt(sq);
        if (len == 0)
        begin
            r.nx = '0;
            r.ny = '0;
            r.nz = '0;
            r.degen = 1'b1;
        end
        else
        begin
            r.nx = scaled_component(nx, len);
            r.ny = scaled_component(ny, len);
            r.nz = scaled_component(nz, len);
            r.degen = 1'b0;
        end
        return r;
    endfunction

    // offer one triangle and wait for its transaction
    task automatic send_triangle(input logic [tun_pkg::IN_DATA_W-1:0] tri_data);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tri_data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_normals.push_back(predict_normal(tri_data));
        triangles_sent++;
        @(negedge clk);
    endtask

    function automatic logic [tun_pkg::IN_DATA_W-1:0] pack_triangle(
        input logic [tun_pkg::COORD_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz);
        return {cz, cy, cx, bz, by, bx, az, ay, ax};
    endfunction

    function automatic logic [tun_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(3))
            0: return tun_pkg::COORD_W'($urandom_range(15)) - 16'd8;
            1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return tun_pkg::COORD_W'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_normals.size() != 0)
            @(negedge clk);
    endtask

    // corners, extremes and degenerate shapes
    task automatic test_directed();
        send_triangle('0);
        send_triangle({9{16'h7fff}});
        send_triangle(pack_triangle(0, 0, 0, 16'h7fff, 0, 0, 0, 16'h7fff, 0));
        send_triangle(pack_triangle(0, 0, 0, 0, 16'h7fff, 0, 16'h7fff, 0, 0));
        send_triangle(pack_triangle(0, 0, 0, 0, 0, 1, 1, 0, 0));
        send_triangle(pack_triangle(0, 0, 0, 0, 1, 0, 0, 0, 1));
        send_triangle(pack_triangle(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
            16'h8000, 16'h8000, 16'h7fff, 16'h8000));
        send_triangle(pack_triangle(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
            16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
        send_triangle(pack_triangle(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
            16'h7fff, 16'h7fff, 16'h8000, 16'h8000));
        // collinear and coincident vertices, plus one small non-degenerate triangle
        send_triangle(pack_triangle(1, 2, 3, 2, 4, 6, 3, 6, 9));
        send_triangle(pack_triangle(16'h8000, 16'h8000, 16'h8000, 0, 0, 0,
            16'h7fff, 16'h7fff, 16'h7fff));
        send_triangle(pack_triangle(5, 5, 5, 5, 5, 5, 9, 1, 3));
        send_triangle(pack_triangle(0, 0, 0, 1, 1, 0, 16'hffff, 16'hffff, 0));
        send_triangle(pack_triangle(0, 0, 0, 1, 0, 0, 1, 1, 1));
        send_triangle({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
            16'haaaa, 16'h5555, 16'haaaa, 16'h5555});
        send_triangle({16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
            16'h5555, 16'haaaa, 16'h5555, 16'haaaa});
    endtask

    // random triangles, some forced collinear
    task automatic test_random(input int count);
        logic [tun_pkg::COORD_W-1:0] v[9];
        int                          k;
        for (int i = 0; i < count; i++)
        begin
            for (int j = 0; j < 9; j++)
                v[j] = rand_coord();
            if ($urandom_range(9) == 0)
            begin
                k = $urandom_range(3) - 1;
                for (int j = 0; j < 3; j++)
                    v[6+j] = v[j] + tun_pkg::COORD_W'(k) * (v[3+j] - v[j]);
            end
            send_triangle(pack_triangle(v[0], v[1], v[2], v[3], v[4], v[5],
                v[6], v[7], v[8]));
        end
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        hold_off = 1'b1;
        test_random(80);
        wait_drained();
    endtask

    // stimulus sequence
    initial
    begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        errors = 0;
        triangles_sent = 0;
        normals_checked = 0;
        degenerate_seen = 0;
        hold_off = 1'b0;
        send_gap_pct = 10;
        recv_stall_pct = 69;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(450);
        wait_drained();
        send_gap_pct = 69;
        recv_stall_pct = 10;
        test_random(450);
        test_backpressure();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random(500);
        wait_drained();
        repeat (LATENCY + 10) @(negedge clk);
        $display("covered %0d triangles and %0d normals, %0d degenerate",
            triangles_sent, normals_checked, degenerate_seen);
        $display("idle mixes on both sides, a long output hold-off and a drain pause");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // receiver ready, with random stalls and one long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        normal_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_normals.size() == 0)
            begin
                $error("normal with no triangle pending");
                errors++;
            end
            else
            begin
                want = expected_normals.pop_front();
                normals_checked++;
                if (m_tuser)
                    degenerate_seen++;
                if (m_tdata[0 +: tun_pkg::NORM_W] !== want.nx)
                begin
                    $error("norm_x expected %0d got %0d", want.nx,
                        $signed(m_tdata[0 +: tun_pkg::NORM_W]));
                    errors++;
                end
                if (m_tdata[tun_pkg::NORM_W +: tun_pkg::NORM_W] !== want.ny)
                begin
                    $error("norm_y expected %0d got %0d", want.ny,
                        $signed(m_tdata[tun_pkg::NORM_W +: tun_pkg::NORM_W]));
                    errors++;
                end
                if (m_tdata[2*tun_pkg::NORM_W +: tun_pkg::NORM_W] !== want.nz)
                begin
                    $error("norm_z expected %0d got %0d", want.nz,
                        $signed(m_tdata[2*tun_pkg::NORM_W +: tun_pkg::NORM_W]));
                    errors++;
                end
                if (m_tuser !== want.degen)
                begin
                    $error("degenerate expected %0d got %0d", want.degen, m_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout with %0d normals outstanding", expected_normals.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
